// File: src/layer_norm_forward_assert.svh
// assertion macros for the layer norm block
`ifndef LAYER_NORM_FORWARD_ASSERT_SVH
`define LAYER_NORM_FORWARD_ASSERT_SVH

// same-cycle implication
`define LNF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lnf_pkg.sv
package lnf_pkg;

	localparam int ROW_MAX_DEF = 64;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int X_W         = 16;
	localparam int D_W         = 23;
	localparam int SQ_W        = 50;
	localparam int DIV_NW      = 50;
	localparam int DIV_DW      = 30;
	localparam int SQRT_RW     = 24;
	localparam int E_W         = 31;
	localparam int NUM_W       = 39;
	localparam int Q_W         = 52;

	localparam logic [LEN_W-1:0] ROW_LEN_RST = 7'd64;
	localparam logic signed [X_W-1:0] SCALE_ONE = 16'sd4096;
	localparam logic signed [X_W-1:0] OFFSET_ZERO = 16'sd0;

	localparam logic CMD_TABLE = 1'b0;
	localparam logic CMD_PUSH  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SQ,
		ST_VARS,
		ST_VARW,
		ST_SQRTS,
		ST_SQRTW,
		ST_DEN,
		ST_RD,
		ST_D,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_OUT
	} lnf_state_t;

endpackage

// File: src/lnf_div.sv
module lnf_div #(
	parameter int NW = lnf_pkg::DIV_NW,
	parameter int DW = lnf_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = ~diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW:0] : rem_sh;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: src/lnf_sqrt.sv
module lnf_sqrt #(
	parameter int RW = lnf_pkg::SQRT_RW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] val,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CW = $clog2(RW + 1);

	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic [2*RW-1:0] val_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+1:0]   rem_sh;
	logic [RW+1:0]   trial;
	logic [RW+2:0]   diff;
	logic            ge;

	// two radicand bits per cycle, one root bit out
	always_comb begin
		rem_sh = {rem_q[RW-1:0], val_q[2*RW-1:2*RW-2]};
		trial  = {root_q, 2'b01};
		diff   = {1'b0, rem_sh} - {1'b0, trial};
		ge     = ~diff[RW+2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(RW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			val_q  <= {val_q[2*RW-3:0], 2'b00};
			rem_q  <= ge ? diff[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: src/layer_norm_forward.sv
// channel   signals                                            dir
// input     in_valid in_stall command entry_index sample       in
//           scale offset
// output    out_valid out_stall result position last           out
// config    row_length_we row_length_wdata                     in
//
// a table write, or a push that does not end the row, does not stall the input
// a push that ends a row of n samples is followed by a sum pass, a squared-deviation pass,
// the variance divide, the square root and the denominator,
// then one result at a time, each held until taken, from the shared bit-serial divider
// in_stall is high after the row-ending push until the last result is taken
// reset: scale 1.0, offset 0, row length 64, row empty
`include "layer_norm_forward_assert.svh"

module layer_norm_forward #(
	parameter int ROW_MAX = lnf_pkg::ROW_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [lnf_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [lnf_pkg::X_W-1:0]      sample,
	input  logic signed [lnf_pkg::X_W-1:0]      scale,
	input  logic signed [lnf_pkg::X_W-1:0]      offset,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lnf_pkg::X_W-1:0]      result,
	output logic [lnf_pkg::IDX_W-1:0]           position,
	output logic                                last,
	input  logic                                row_length_we,
	input  logic [lnf_pkg::LEN_W-1:0]           row_length_wdata
);

	localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
	localparam int LW = lnf_pkg::LEN_W;
	localparam int XW = lnf_pkg::X_W;
	localparam int DW = lnf_pkg::D_W;
	localparam logic [LW-1:0] ROW_MAX_N = LW'(ROW_MAX);

	lnf_pkg::lnf_state_t state_q, state_d;

	logic [LW-1:0] row_len_q;
	logic [LW-1:0] fill_q;
	logic [LW-1:0] n_q;
	logic [LW-1:0] cnt_q;
	logic          out_valid_q;
	logic          vld_s1, vld_s2, vld_s3;

	logic signed [XW-1:0] row_mem [ROW_MAX];
	logic signed [XW-1:0] scale_mem [ROW_MAX];
	logic signed [XW-1:0] offset_mem [ROW_MAX];
	logic [ROW_MAX-1:0]   tab_vld_q;

	logic signed [XW-1:0] x_s1, scl_s1, ofs_s1;
	logic signed [DW-1:0] sum_q;
	logic signed [DW-1:0] d_s2;
	logic signed [2*DW-1:0] sq_s3;
	logic [lnf_pkg::SQ_W-1:0] sumsq_q;
	logic [12:0] n2_q;
	logic [18:0] n3_q;
	logic [lnf_pkg::E_W-1:0] e_q;
	logic [lnf_pkg::DIV_DW-1:0] den_q;
	logic signed [DW-1:0] d_q;
	logic signed [lnf_pkg::NUM_W-1:0] num_q;
	logic signed [XW-1:0] result_q;
	logic [lnf_pkg::IDX_W-1:0] position_q;
	logic last_q;

	logic in_accept, push_done, rd_en, tab_we, out_take;
	logic [LW-1:0] n_eff, fill_inc;
	logic [AW-1:0] rd_addr;
	logic signed [DW:0] nx;
	logic [lnf_pkg::NUM_W+3:0] num_sh, mag;
	logic [lnf_pkg::DIV_NW-1:0] div_num, quo;
	logic [lnf_pkg::DIV_DW-1:0] div_den;
	logic div_start, div_done, sqrt_start, sqrt_done;
	logic [lnf_pkg::SQRT_RW-1:0] root;
	logic signed [lnf_pkg::Q_W-1:0] q_s, tot;
	logic signed [XW-1:0] res_sat;

	assign in_accept = in_valid & ~in_stall;
	assign out_take  = out_valid_q & ~out_stall;
	assign tab_we    = in_accept & (command == lnf_pkg::CMD_TABLE)
		& ({1'b0, entry_index} < ROW_MAX_N);

	always_comb begin
		if (row_len_q == '0) begin
			n_eff = LW'(1);
		end else if (row_len_q > ROW_MAX_N) begin
			n_eff = ROW_MAX_N;
		end else begin
			n_eff = row_len_q;
		end
		fill_inc  = fill_q + 1'b1;
		push_done = fill_inc >= n_eff;
		rd_addr   = cnt_q[AW-1:0];
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		in_stall   = (state_q != lnf_pkg::ST_IDLE);
		case (state_q)
			lnf_pkg::ST_IDLE: begin
				if (in_accept && command == lnf_pkg::CMD_PUSH && push_done) begin
					state_d = lnf_pkg::ST_SUM;
				end
			end
			lnf_pkg::ST_SUM: begin
				rd_en = cnt_q < n_q;
				if (cnt_q == n_q && !vld_s1) begin
					state_d = lnf_pkg::ST_SQ;
				end
			end
			lnf_pkg::ST_SQ: begin
				rd_en = cnt_q < n_q;
				if (cnt_q == n_q && !vld_s1 && !vld_s2 && !vld_s3) begin
					state_d = lnf_pkg::ST_VARS;
				end
			end
			lnf_pkg::ST_VARS: begin
				div_start = 1'b1;
				state_d   = lnf_pkg::ST_VARW;
			end
			lnf_pkg::ST_VARW: begin
				if (div_done) begin
					state_d = lnf_pkg::ST_SQRTS;
				end
			end
			lnf_pkg::ST_SQRTS: begin
				sqrt_start = 1'b1;
				state_d    = lnf_pkg::ST_SQRTW;
			end
			lnf_pkg::ST_SQRTW: begin
				if (sqrt_done) begin
					state_d = lnf_pkg::ST_DEN;
				end
			end
			lnf_pkg::ST_DEN: state_d = lnf_pkg::ST_RD;
			lnf_pkg::ST_RD: begin
				rd_en   = 1'b1;
				state_d = lnf_pkg::ST_D;
			end
			lnf_pkg::ST_D:   state_d = lnf_pkg::ST_MUL;
			lnf_pkg::ST_MUL: state_d = lnf_pkg::ST_DIVS;
			lnf_pkg::ST_DIVS: begin
				div_start = 1'b1;
				state_d   = lnf_pkg::ST_DIVW;
			end
			lnf_pkg::ST_DIVW: begin
				if (div_done) begin
					state_d = lnf_pkg::ST_OUT;
				end
			end
			lnf_pkg::ST_OUT: begin
				if (out_take) begin
					state_d = last_q ? lnf_pkg::ST_IDLE : lnf_pkg::ST_RD;
				end
			end
			default: state_d = lnf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lnf_pkg::ST_IDLE;
			row_len_q   <= lnf_pkg::ROW_LEN_RST;
			fill_q      <= '0;
			n_q         <= LW'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			tab_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (row_length_we) begin
				row_len_q <= row_length_wdata;
			end
			if (tab_we) begin
				tab_vld_q[entry_index[AW-1:0]] <= 1'b1;
			end
			if (in_accept && command == lnf_pkg::CMD_PUSH) begin
				if (push_done) begin
					fill_q <= '0;
					n_q    <= n_eff;
					cnt_q  <= '0;
				end else begin
					fill_q <= fill_inc;
				end
			end
			vld_s1 <= rd_en && (state_q == lnf_pkg::ST_SUM || state_q == lnf_pkg::ST_SQ);
			vld_s2 <= vld_s1 && (state_q == lnf_pkg::ST_SQ);
			vld_s3 <= vld_s2;
			if ((state_q == lnf_pkg::ST_SUM || state_q == lnf_pkg::ST_SQ) && rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == lnf_pkg::ST_SUM && state_d == lnf_pkg::ST_SQ) begin
				cnt_q <= '0;
			end
			if (state_q == lnf_pkg::ST_DEN) begin
				cnt_q <= '0;
			end
			if (state_q == lnf_pkg::ST_DIVW && div_done) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
				cnt_q       <= cnt_q + 1'b1;
			end
		end
	end

	// row store and tables, registered reads
	always_ff @(posedge clk) begin
		if (in_accept && command == lnf_pkg::CMD_PUSH && fill_q < ROW_MAX_N) begin
			row_mem[fill_q[AW-1:0]] <= sample;
		end
		if (tab_we) begin
			scale_mem[entry_index[AW-1:0]]  <= scale;
			offset_mem[entry_index[AW-1:0]] <= offset;
		end
		if (rd_en) begin
			x_s1   <= row_mem[rd_addr];
			scl_s1 <= tab_vld_q[rd_addr] ? scale_mem[rd_addr] : lnf_pkg::SCALE_ONE;
			ofs_s1 <= tab_vld_q[rd_addr] ? offset_mem[rd_addr] : lnf_pkg::OFFSET_ZERO;
		end
	end

	always_comb begin
		nx      = (DW+1)'(signed'({1'b0, n_q}) * x_s1);
		num_sh  = {num_q, 4'b0000};
		mag     = num_q[lnf_pkg::NUM_W-1] ? (~num_sh + 1'b1) : num_sh;
		div_num = (state_q == lnf_pkg::ST_VARS) ? sumsq_q
			: lnf_pkg::DIV_NW'(mag) + lnf_pkg::DIV_NW'(den_q >> 1);
		div_den = (state_q == lnf_pkg::ST_VARS) ? lnf_pkg::DIV_DW'(n3_q) : den_q;
		q_s     = num_q[lnf_pkg::NUM_W-1] ? -signed'({2'b00, quo}) : signed'({2'b00, quo});
		tot     = q_s + lnf_pkg::Q_W'(ofs_s1);
		if (tot > 32767) begin
			res_sat = 16'sh7fff;
		end else if (tot < -32768) begin
			res_sat = 16'sh8000;
		end else begin
			res_sat = tot[XW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lnf_pkg::ST_IDLE) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end
		if (state_q == lnf_pkg::ST_SUM) begin
			n2_q <= 13'(n_q * n_q);
			n3_q <= 19'(n2_q * n_q);
			if (vld_s1) begin
				sum_q <= sum_q + DW'(x_s1);
			end
		end
		// deviation, square, accumulate
		d_s2  <= nx[DW-1:0] - sum_q;
		sq_s3 <= d_s2 * d_s2;
		if (state_q == lnf_pkg::ST_SQ && vld_s3) begin
			sumsq_q <= sumsq_q + lnf_pkg::SQ_W'(unsigned'(sq_s3));
		end
		if (state_q == lnf_pkg::ST_VARW && div_done) begin
			e_q <= quo[lnf_pkg::E_W-1:0] + 1'b1;
		end
		if (state_q == lnf_pkg::ST_DEN) begin
			den_q <= lnf_pkg::DIV_DW'(n_q * root);
		end
		if (state_q == lnf_pkg::ST_D) begin
			d_q <= nx[DW-1:0] - sum_q;
		end
		if (state_q == lnf_pkg::ST_MUL) begin
			num_q <= lnf_pkg::NUM_W'(d_q * scl_s1);
		end
		if (state_q == lnf_pkg::ST_DIVW && div_done) begin
			result_q   <= res_sat;
			position_q <= cnt_q[lnf_pkg::IDX_W-1:0];
			last_q     <= (cnt_q + 1'b1) == n_q;
		end
	end

	lnf_div #(
		.NW(lnf_pkg::DIV_NW),
		.DW(lnf_pkg::DIV_DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	lnf_sqrt #(
		.RW(lnf_pkg::SQRT_RW)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.val   ({1'b0, e_q, 16'h0000}),
		.done  (sqrt_done),
		.root  (root)
	);

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign position  = position_q;
	assign last      = last_q;

	`LNF_ASSERT_NOW(a_busy_out, out_valid_q, in_stall, "request accepted while results pending")
	`LNF_ASSERT_NEXT(a_mid_row, out_take && !last_q, state_q == lnf_pkg::ST_RD,
		"row ended before last result")
	`LNF_ASSERT_NOW(a_div_own, div_done,
		state_q == lnf_pkg::ST_VARW || state_q == lnf_pkg::ST_DIVW, "stray divider completion")

endmodule
